// ===== sv/mandelbrot_escape_time_core_assert.svh =====
// Assertion macros shared by the RTL files of the escape-time core.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define MET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Antecedent in a cycle implies the consequent in the next cycle.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/met_pkg.sv =====
// Shared types, constants and helper functions of the escape-time core.
// No dependencies; every other file but the assertion header uses this package.
package met_pkg;

	localparam int PIX_W     = 9;
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 28;
	localparam int MAX_ITER  = 100;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Width that holds a mapped coordinate before saturation.
	localparam int WIDE_W = 42;

	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ITER);
	localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(MAX_ITER / 2);

	// 4.0 in Q8.56.
	localparam logic [63:0] FOUR_Q56 = 64'h0400_0000_0000_0000;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 42'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -42'sd2147483648;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_REAL = 2'd0,
		REG_TOP_IMAG  = 2'd1,
		REG_REAL_STEP = 2'd2,
		REG_IMAG_STEP = 2'd3
	} reg_idx_t;

	localparam coord_t LEFT_REAL_RST = -32'sd536870912;
	localparam coord_t TOP_IMAG_RST  = 32'sd536870912;
	localparam coord_t REAL_STEP_RST = 32'sd2101255;
	localparam coord_t IMAG_STEP_RST = 32'sd2101255;

	typedef struct packed {
		coord_t left_real;
		coord_t top_imag;
		coord_t real_step;
		coord_t imag_step;
	} cfg_t;

	// One mapped point on its way from the front to the back.
	typedef struct packed {
		coord_t cre;
		coord_t cim;
		logic   outside;
	} point_t;

	// Clamp a wide signed value to the Q4.28 range.
	function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
		coord_t r;
		if (v > SAT_HI) begin
			r = coord_t'(SAT_HI[COORD_W-1:0]);
		end else if (v < SAT_LO) begin
			r = coord_t'(SAT_LO[COORD_W-1:0]);
		end else begin
			r = coord_t'(v[COORD_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== sv/met_pix_if.sv =====
// Input channel of the escape-time core: one pixel coordinate per item.
// Depends on met_pkg for the field width.
interface met_pix_if;
	logic                       valid;
	logic                       ready;
	logic [met_pkg::PIX_W-1:0] pixel_x;
	logic [met_pkg::PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== sv/met_cnt_if.sv =====
// Output channel of the escape-time core: one escape count per item.
// Depends on met_pkg for the field width.
interface met_cnt_if;
	logic                       valid;
	logic                       ready;
	logic [met_pkg::CNT_W-1:0] escape_count;

	modport source (output valid, output escape_count, input ready);
	modport sink (input valid, input escape_count, output ready);
endinterface

// ===== sv/met_front.sv =====
// Front of the escape-time core: maps a pixel to a complex point and flags
// points outside radius two. Depends on met_pkg and met_pix_if.
module met_front (
	input  logic            clk,
	input  logic            arst_n,
	met_pix_if.sink         pix,
	input  met_pkg::cfg_t   cfg,
	output met_pkg::point_t pt,
	output logic            pt_valid,
	input  logic            pt_ready
);
	import met_pkg::*;

	logic                     adv;
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [WIDE_W-1:0] xp_s1, yp_s1;
	coord_t                   cre_s2, cim_s2, cre_s3, cim_s3;
	logic [63:0]              sq_re_s3, sq_im_s3;
	logic [63:0]              mag;
	point_t                   pt_s4;

	// The whole pipe moves together unless the last stage is stuck.
	assign adv      = !(v_s4 && !pt_ready);
	assign pix.ready = adv;
	assign mag      = sq_re_s3 + sq_im_s3;
	assign pt       = pt_s4;
	assign pt_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s1    <= WIDE_W'(signed'({1'b0, pix.pixel_x})) * WIDE_W'(cfg.real_step);
			yp_s1    <= WIDE_W'(signed'({1'b0, pix.pixel_y})) * WIDE_W'(cfg.imag_step);
			cre_s2   <= sat_coord(WIDE_W'(cfg.left_real) + xp_s1);
			cim_s2   <= sat_coord(WIDE_W'(cfg.top_imag) - yp_s1);
			sq_re_s3 <= cre_s2 * cre_s2;
			sq_im_s3 <= cim_s2 * cim_s2;
			cre_s3   <= cre_s2;
			cim_s3   <= cim_s2;
			pt_s4    <= '{cre: cre_s3, cim: cim_s3, outside: (mag > FOUR_Q56)};
		end
	end

endmodule

// ===== sv/met_queue.sv =====
// Two-entry queue between the front and the back of the escape-time core.
// Depends on met_pkg for the point type.
module met_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  met_pkg::point_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output met_pkg::point_t pop_data,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import met_pkg::*;

	point_t     ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/met_back.sv =====
// Back of the escape-time core: runs the z = z^2 + c rounds for one point at
// a time and holds the result. Depends on met_pkg and met_cnt_if.
`include "mandelbrot_escape_time_core_assert.svh"

module met_back (
	input  logic            clk,
	input  logic            arst_n,
	input  met_pkg::point_t pt,
	input  logic            pt_valid,
	output logic            pt_ready,
	met_cnt_if.source       res
);
	import met_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_FIN} state_t;

	state_t                   state_q;
	coord_t                   cre_q, cim_q, zre_q, zim_q;
	logic [63:0]              rr_q, ii_q;
	logic signed [63:0]       ri_q;
	logic [CNT_W-1:0]         iter_q, res_q, ocount_q;
	logic                     ovalid_q;
	logic [63:0]              mag;
	logic                     escape;
	logic signed [63:0]       diff;
	logic signed [WIDE_W-1:0] nre_w, nim_w;

	// The magnitude is the sum of the two squares formed for this round.
	assign mag    = rr_q + ii_q;
	assign escape = (mag > FOUR_Q56);
	assign diff   = signed'(rr_q - ii_q);
	assign nre_w  = WIDE_W'(signed'(diff[63:FRAC_BITS])) + WIDE_W'(cre_q);
	assign nim_w  = WIDE_W'(signed'(ri_q[63:FRAC_BITS-1])) + WIDE_W'(cim_q);

	assign pt_ready         = (state_q == ST_IDLE);
	assign res.valid        = ovalid_q;
	assign res.escape_count = ocount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			iter_q   <= '0;
			res_q    <= '0;
			ovalid_q <= 1'b0;
			ocount_q <= '0;
			cre_q    <= '0;
			cim_q    <= '0;
			zre_q    <= '0;
			zim_q    <= '0;
			rr_q     <= '0;
			ii_q     <= '0;
			ri_q     <= '0;
		end else begin
			// In the finishing state the output register is either refilled or
			// held, so it is only emptied here in the other states.
			if (ovalid_q && res.ready && (state_q != ST_FIN)) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pt_valid) begin
						cre_q  <= pt.cre;
						cim_q  <= pt.cim;
						zre_q  <= pt.cre;
						zim_q  <= pt.cim;
						iter_q <= '0;
						if (pt.outside) begin
							res_q   <= CNT_HALF;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					rr_q    <= zre_q * zre_q;
					ii_q    <= zim_q * zim_q;
					ri_q    <= zre_q * zim_q;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (escape) begin
						res_q   <= CNT_MAX - iter_q;
						state_q <= ST_FIN;
					end else if (iter_q == CNT_MAX) begin
						res_q   <= CNT_MAX;
						state_q <= ST_FIN;
					end else begin
						zre_q   <= sat_coord(nre_w);
						zim_q   <= sat_coord(nim_w);
						iter_q  <= iter_q + CNT_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (!ovalid_q || res.ready) begin
						ovalid_q <= 1'b1;
						ocount_q <= res_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MET_ASSERT(a_iter_range, iter_q <= CNT_MAX, "round count beyond the iteration limit")
	`MET_ASSERT(a_first_round, (state_q == ST_UPD) && (iter_q == '0) |-> !escape, "inside point escaped in its first round")
	`MET_ASSERT_NEXT(a_outside_half, (state_q == ST_IDLE) && pt_valid && pt.outside, (state_q == ST_FIN) && (res_q == CNT_HALF), "outside point not answered with half the limit")

endmodule

// ===== sv/mandelbrot_escape_time_core.sv =====
// Mandelbrot escape-time core: pixel in, gray level out, one result per item.
// Depends on met_pkg, met_pix_if, met_cnt_if, met_front, met_queue and met_back.
//
// Each item on pix carries a pixel (pixel_x, pixel_y). The front maps it to
// c = (left_real + pixel_x*real_step) + i*(top_imag - pixel_y*imag_step), all in
// signed Q4.28 with saturation, and flags points with |c|^2 above 4. It is a
// registered pipeline and can accept one item per cycle unless its last stage
// is held up. A two-entry queue decouples it from the back, which handles one
// point at a time: a flagged point goes straight to the finishing state and is
// answered with MAX_ITER/2; any other point runs up to MAX_ITER+1 rounds of
// z = z^2 + c on one shared set of three 32x32 multipliers, each round a
// product state followed by a state for the escape test and the update.
// That loop sets the sustained rate. The result sits in an output register
// while the back already takes the next point. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no item
// is in flight; there is no read-back.
`include "mandelbrot_escape_time_core_assert.svh"

module mandelbrot_escape_time_core (
	input  logic                            clk,
	input  logic                            arst_n,
	met_pix_if.sink                         pix,
	met_cnt_if.source                       res,
	input  logic                            cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [met_pkg::COORD_W-1:0]     cfg_data
);
	import met_pkg::*;

	cfg_t   cfg_q;
	point_t f_pt, q_pt;
	logic   f_valid, f_ready, q_valid, q_ready;

	// Register file; the index decodes straight onto the four registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_real <= LEFT_REAL_RST;
			cfg_q.top_imag  <= TOP_IMAG_RST;
			cfg_q.real_step <= REAL_STEP_RST;
			cfg_q.imag_step <= IMAG_STEP_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT_REAL: cfg_q.left_real <= coord_t'(cfg_data);
				REG_TOP_IMAG:  cfg_q.top_imag  <= coord_t'(cfg_data);
				REG_REAL_STEP: cfg_q.real_step <= coord_t'(cfg_data);
				REG_IMAG_STEP: cfg_q.imag_step <= coord_t'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Front: mapping and the radius-two test.
	met_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.cfg      (cfg_q),
		.pt       (f_pt),
		.pt_valid (f_valid),
		.pt_ready (f_ready)
	);

	// Queue that lets the front keep accepting while the back iterates.
	met_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (f_pt),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_data   (q_pt),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	// Back: the iteration loop and the output register.
	met_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt       (q_pt),
		.pt_valid (q_valid),
		.pt_ready (q_ready),
		.res      (res)
	);

endmodule

// ===== test/mandelbrot_escape_time_core_test.sv =====
// Self-checking testbench for mandelbrot_escape_time_core: pixels in, gray levels out.
// Depends on met_pkg, met_pix_if, met_cnt_if and the core itself; reads no files.
module mandelbrot_escape_time_core_test;
	import met_pkg::*;

	// Random pixels, spread evenly over the views programmed after the directed part.
	localparam int N_RANDOM       = 1800;
	localparam int N_VIEWS_RANDOM = 8;
	// Long receiver hold-off so that the front, the queue and the output register fill up.
	localparam int HOLD_CYCLES    = 3000;
	// Worst case for one point: every round of the escape loop plus the mapping front.
	localparam int POINT_CYCLES   = 2 * (MAX_ITER + 1) + 2 + 4;
	localparam int SETTLE_CYCLES  = 8;
	// Every item at its slowest, with the longest gap and stall, taken three times over.
	localparam longint LIMIT_CYCLES =
		3 * (N_RANDOM + 32) * (POINT_CYCLES + 8 + 8 + 2) + HOLD_CYCLES + 10000;

	// How a random view of the plane is chosen.
	typedef enum {VIEW_RESET, VIEW_ZOOM, VIEW_WILD, VIEW_MIRROR} view_kind_t;

	localparam view_kind_t VIEW_PLAN [N_VIEWS_RANDOM] = '{VIEW_RESET, VIEW_ZOOM, VIEW_ZOOM,
		VIEW_WILD, VIEW_MIRROR, VIEW_ZOOM, VIEW_RESET, VIEW_ZOOM};

	// One row of the directed table: the view it needs, the pixel, and a typed-in
	// gray level where the answer is obvious.
	typedef struct {
		cfg_t                 view;
		logic [PIX_W-1:0]     px;
		logic [PIX_W-1:0]     py;
		bit                   typed;
		logic [CNT_W-1:0]     gray;
	} probe_t;

	// Fixed views for the directed part.
	localparam cfg_t V_RESET = '{LEFT_REAL_RST, TOP_IMAG_RST, REAL_STEP_RST, IMAG_STEP_RST};
	// Every pixel lands on c = -2, which lies exactly on the circle of radius two.
	localparam cfg_t V_MINUS_TWO = '{-32'sd536870912, 32'sd0, 32'sd0, 32'sd0};
	// c = +2 and c = 2i: on the circle at first, escaping in the second round.
	localparam cfg_t V_PLUS_TWO  = '{32'sd536870912, 32'sd0, 32'sd0, 32'sd0};
	localparam cfg_t V_IMAG_TWO  = '{32'sd0, 32'sd536870912, 32'sd0, 32'sd0};
	// Register extremes that drive the mapped coordinates into saturation.
	localparam cfg_t V_SAT_A = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
	localparam cfg_t V_SAT_B = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
	// All zero: every pixel is the origin, a member.
	localparam cfg_t V_ORIGIN = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
	// A small window on the boundary near -0.75 + 0.11i, rich in long orbits.
	localparam cfg_t V_SEAHORSE = '{-32'sd200063000, 32'sd30250000, 32'sd16384, 32'sd16384};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	met_pix_if pix_ch ();
	met_cnt_if res_ch ();

	mandelbrot_escape_time_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The view the core holds right now, as far as the testbench has written it.
	cfg_t             view_now;
	// Gray levels still owed by the core, oldest first.
	logic [CNT_W-1:0] gray_fifo [$];
	int               mismatches = 0;
	int               grays_checked = 0;
	int               views_set;
	int               n_outside = 0;
	int               n_member = 0;
	longint           cycle_count = 0;
	// Requests from the pixel side to the result side: one long hold-off, and
	// stretches where neither side idles.
	bit               hold_req;
	bit               calm;

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// Clamp a wide value to the signed Q4.28 range.
	function automatic coord_t clamp_q428(input longint v);
		if (v > 64'sd2147483647) begin
			return coord_t'(32'sh7FFF_FFFF);
		end
		if (v < -64'sd2147483648) begin
			return coord_t'(32'sh8000_0000);
		end
		return coord_t'(v[COORD_W-1:0]);
	endfunction

	// Exact |re + i*im|^2 in unsigned Q8.56.
	function automatic logic [63:0] mag_q56(input coord_t re, input coord_t im);
		longint          a;
		longint          b;
		longint unsigned ua;
		longint unsigned ub;
		a = re;
		b = im;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		return ua * ua + ub * ub;
	endfunction

	// Gray level of one pixel under a view: map the pixel to c, answer half the
	// iteration budget outside radius two, otherwise iterate z = z^2 + c with
	// floor rounding back to Q4.28 and saturation, and count the rounds left.
	function automatic logic [CNT_W-1:0] escape_gray(input cfg_t v, input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] py);
		longint left_w;
		longint top_w;
		longint rstep;
		longint istep;
		longint xl;
		longint yl;
		longint rr;
		longint ii;
		longint ri;
		coord_t cre;
		coord_t cim;
		coord_t zre;
		coord_t zim;
		left_w = v.left_real;
		top_w = v.top_imag;
		rstep = v.real_step;
		istep = v.imag_step;
		xl = px;
		yl = py;
		cre = clamp_q428(left_w + xl * rstep);
		cim = clamp_q428(top_w - yl * istep);
		if (mag_q56(cre, cim) > FOUR_Q56) begin
			return CNT_HALF;
		end
		zre = cre;
		zim = cim;
		for (int k = 0; k <= MAX_ITER; k++) begin
			// A magnitude of exactly four is not an escape.
			if (mag_q56(zre, zim) > FOUR_Q56) begin
				return CNT_W'(MAX_ITER - k);
			end
			rr = longint'(zre) * longint'(zre);
			ii = longint'(zim) * longint'(zim);
			ri = longint'(zre) * longint'(zim);
			zre = clamp_q428(((rr - ii) >>> FRAC_BITS) + longint'(cre));
			zim = clamp_q428((ri >>> (FRAC_BITS - 1)) + longint'(cim));
		end
		return CNT_MAX;
	endfunction

	// A view drawn at random. Zoomed and mirrored windows center on the part of
	// the plane where the set lives, so most pixels run real orbits; wild views
	// take any register values at all.
	function automatic cfg_t random_view(input view_kind_t kind);
		cfg_t v;
		int   step;
		int   cx;
		int   cy;
		step = int'($urandom_range(1 << 10, 1 << 21));
		cx = int'($urandom_range(0, 671088640)) - 536870912;
		cy = int'($urandom_range(0, 671088640)) - 335544320;
		case (kind)
			VIEW_RESET: begin
				v = V_RESET;
			end
			VIEW_WILD: begin
				v = '{$urandom(), $urandom(), $urandom(), $urandom()};
			end
			VIEW_MIRROR: begin
				v = '{cx + 256 * step, cy - 256 * step, -step, -step};
			end
			default: begin
				v = '{cx - 256 * step, cy + 256 * step, step, step};
			end
		endcase
		return v;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input coord_t d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// Write all four registers, one per cycle. Only called with the core idle.
	task automatic program_view(input cfg_t v);
		write_reg(REG_LEFT_REAL, v.left_real);
		write_reg(REG_TOP_IMAG, v.top_imag);
		write_reg(REG_REAL_STEP, v.real_step);
		write_reg(REG_IMAG_STEP, v.imag_step);
		cfg_we <= 1'b0;
		view_now = v;
		views_set++;
	endtask

	// Stop offering pixels and wait until every owed gray level has come back.
	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (gray_fifo.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one pixel after a random gap and note what it must turn into. Valid
	// stays high across back-to-back items, so it is never lowered and raised in
	// the same step.
	task automatic offer_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
			input bit typed, input logic [CNT_W-1:0] gray);
		int gap;
		gap = calm ? 0 : int'($urandom_range(0, 8));
		if (gap != 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_x <= px;
		pix_ch.pixel_y <= py;
		do begin
			@(posedge clk);
		end while (!pix_ch.ready);
		gray_fifo.push_back(typed ? gray : escape_gray(view_now, px, py));
	endtask

	// Result side: stall at random, once for a long stretch on request, and
	// compare every accepted gray level with the oldest one owed.
	initial begin
		int               stall;
		logic [CNT_W-1:0] want;
		bit               held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = calm ? 0 : int'($urandom_range(0, 8));
				if (stall != 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!res_ch.valid);
			if (gray_fifo.size() == 0) begin
				$error("escape_count: unexpected item, actual %0d", res_ch.escape_count);
				mismatches++;
			end else begin
				want = gray_fifo.pop_front();
				if (res_ch.escape_count !== want) begin
					$error("escape_count: expected %0d, actual %0d", want,
						res_ch.escape_count);
					mismatches++;
				end
			end
			grays_checked++;
			if (res_ch.escape_count === CNT_HALF) begin
				n_outside++;
			end
			if (res_ch.escape_count === CNT_MAX) begin
				n_member++;
			end
		end
	end

	// Pixel side: reset, the directed table, then the random views.
	initial begin
		probe_t rows [$];
		views_set = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		view_now = V_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LEFT_REAL;
		cfg_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_x <= '0;
		pix_ch.pixel_y <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: the corners lie outside radius two, the center runs long.
		rows.push_back('{V_RESET, 9'd0, 9'd0, 1'b1, CNT_HALF});
		rows.push_back('{V_RESET, 9'd511, 9'd511, 1'b1, CNT_HALF});
		rows.push_back('{V_RESET, 9'd511, 9'd0, 1'b1, CNT_HALF});
		rows.push_back('{V_RESET, 9'd0, 9'd511, 1'b1, CNT_HALF});
		rows.push_back('{V_RESET, 9'd256, 9'd256, 1'b0, '0});
		rows.push_back('{V_RESET, 9'd0, 9'd256, 1'b0, '0});
		rows.push_back('{V_RESET, 9'd256, 9'd0, 1'b0, '0});
		rows.push_back('{V_RESET, 9'd128, 9'd300, 1'b0, '0});
		// Exactly on the circle: c = -2 counts as inside and its orbit sits at
		// magnitude four forever, so it never escapes.
		rows.push_back('{V_MINUS_TWO, 9'd0, 9'd0, 1'b1, CNT_MAX});
		rows.push_back('{V_MINUS_TWO, 9'd511, 9'd511, 1'b1, CNT_MAX});
		// On the circle at round zero, far outside at round one.
		rows.push_back('{V_PLUS_TWO, 9'd0, 9'd0, 1'b1, CNT_W'(MAX_ITER - 1)});
		rows.push_back('{V_IMAG_TWO, 9'd300, 9'd7, 1'b1, CNT_W'(MAX_ITER - 1)});
		// Saturated mapping in every direction.
		rows.push_back('{V_SAT_A, 9'd0, 9'd0, 1'b1, CNT_HALF});
		rows.push_back('{V_SAT_A, 9'd511, 9'd511, 1'b1, CNT_HALF});
		rows.push_back('{V_SAT_A, 9'd1, 9'd0, 1'b1, CNT_HALF});
		rows.push_back('{V_SAT_A, 9'd511, 9'd0, 1'b1, CNT_HALF});
		rows.push_back('{V_SAT_B, 9'd0, 9'd0, 1'b1, CNT_HALF});
		rows.push_back('{V_SAT_B, 9'd511, 9'd511, 1'b1, CNT_HALF});
		rows.push_back('{V_SAT_B, 9'd0, 9'd511, 1'b1, CNT_HALF});
		// The origin is a member whatever the pixel.
		rows.push_back('{V_ORIGIN, 9'd0, 9'd0, 1'b1, CNT_MAX});
		rows.push_back('{V_ORIGIN, 9'd511, 9'd511, 1'b1, CNT_MAX});
		rows.push_back('{V_SEAHORSE, 9'd0, 9'd0, 1'b0, '0});
		rows.push_back('{V_SEAHORSE, 9'd255, 9'd255, 1'b0, '0});
		rows.push_back('{V_SEAHORSE, 9'd511, 9'd511, 1'b0, '0});

		foreach (rows[i]) begin
			if (i == 0 || rows[i].view != view_now) begin
				drain();
				program_view(rows[i].view);
			end
			offer_pixel(rows[i].px, rows[i].py, rows[i].typed, rows[i].gray);
		end

		// Random part: one view per phase. The first phase starts with the long
		// hold-off on the result side; one later phase runs with no idling at all.
		for (int p = 0; p < N_VIEWS_RANDOM; p++) begin
			drain();
			program_view(random_view(VIEW_PLAN[p]));
			calm = (p == 6);
			if (p == 0) begin
				hold_req = 1'b1;
			end
			repeat (N_RANDOM / N_VIEWS_RANDOM) begin
				offer_pixel(PIX_W'($urandom_range(0, 511)), PIX_W'($urandom_range(0, 511)),
					1'b0, '0);
			end
		end
		calm = 1'b0;

		drain();
		repeat (POINT_CYCLES) @(posedge clk);

		$display("Checked %0d gray levels over %0d programmed views.", grays_checked, views_set);
		$display("Of these %0d got half the budget and %0d the full budget.", n_outside,
			n_member);
		if (mismatches == 0 && gray_fifo.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
